FILE: rtl/core/polynomial_add_multiply_assert.svh
// Assertion macros for the polynomial add/multiply block.
// Used by the top level; needs no package and no other header.
`ifndef POLYNOMIAL_ADD_MULTIPLY_ASSERT_SVH
`define POLYNOMIAL_ADD_MULTIPLY_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define PAM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pam assertion failed");
// Next-cycle implication, checked out of reset.
`define PAM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pam assertion failed");
`else
`define PAM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define PAM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/core/pam_pkg.sv
// Shared constants, request codes and the result type of the polynomial block.
// Used by pam_ram, pam_seq and polynomial_add_multiply; depends on nothing.
`default_nettype none

package pam_pkg;

    // Default highest exponent kept per operand.
    localparam int MAX_EXP_DEF = 15;

    // Field widths.
    localparam int COEF_W = 32;
    localparam int TEXP_W = 4;
    localparam int OEXP_W = 5;
    localparam int REQ_W  = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

    // Section codes.
    localparam logic SECT_SUM  = 1'b0;
    localparam logic SECT_PROD = 1'b1;

    // One result term.
    typedef struct packed {
        logic              section;
        logic [COEF_W-1:0] coef;
        logic [OEXP_W-1:0] exponent;
        logic              last;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/core/pam_ram.sv
// Single-port-write, single-port-read coefficient memory with a registered
// read and per-entry valid bits; unwritten entries read as zero. Uses pam_pkg.
`default_nettype none

module pam_ram
    import pam_pkg::*;
#(
    parameter int DEPTH = MAX_EXP_DEF + 1,
    parameter int WIDTH = COEF_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_clr,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;

    // Storage array, written without reset.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Valid bits: an entry never written since the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clr) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/pam_seq.sv
// Sequencer of the polynomial block: holds the two operand memories and the
// product memory and walks them for loads, the sum and the product.
// Uses pam_pkg and pam_ram.
`default_nettype none

module pam_seq
    import pam_pkg::*;
#(
    parameter int MAX_EXP = MAX_EXP_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [COEF_W-1:0] i_coef,
    input  wire logic [TEXP_W-1:0] i_exp,
    output logic                   o_push_valid,
    input  wire logic              i_push_ready,
    output t_res                   o_push
);

    localparam int NTERM = MAX_EXP + 1;
    localparam int NPROD = 2 * MAX_EXP + 1;
    localparam int AW    = $clog2(NTERM);
    localparam int PW    = $clog2(NPROD);
    localparam logic [AW-1:0] LAST_IDX  = AW'(MAX_EXP);
    localparam logic [PW-1:0] LAST_PIDX = PW'(2 * MAX_EXP);

    // State codes.
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_LD_WR     = 4'd1;
    localparam logic [3:0] S_SUM_RD    = 4'd2;
    localparam logic [3:0] S_SUM_CHK   = 4'd3;
    localparam logic [3:0] S_SUM_EMPTY = 4'd4;
    localparam logic [3:0] S_PR_RD     = 4'd5;
    localparam logic [3:0] S_PR_MUL    = 4'd6;
    localparam logic [3:0] S_PR_WR     = 4'd7;
    localparam logic [3:0] S_PE_RD     = 4'd8;
    localparam logic [3:0] S_PE_CHK    = 4'd9;
    localparam logic [3:0] S_PE_FIN    = 4'd10;

    logic [3:0]        r_state,     n_state;
    logic [AW-1:0]     r_ld_addr,   n_ld_addr;
    logic              r_ld_b,      n_ld_b;
    logic [COEF_W-1:0] r_coef,      n_coef;
    logic [AW-1:0]     r_e,         n_e;
    logic [AW-1:0]     r_i,         n_i;
    logic [AW-1:0]     r_j,         n_j;
    logic [PW-1:0]     r_pe,        n_pe;
    logic              r_found,     n_found;
    logic [COEF_W-1:0] r_prod,      n_prod;
    logic              r_pend_vld,  n_pend_vld;
    logic [COEF_W-1:0] r_pend_coef, n_pend_coef;
    logic [OEXP_W-1:0] r_pend_exp,  n_pend_exp;

    // Memory ports.
    logic              a_re, a_we, b_re, b_we, p_re, p_we, mem_clr;
    logic [AW-1:0]     a_raddr, b_raddr;
    logic [PW-1:0]     p_addr;
    logic [COEF_W-1:0] a_wdata, b_wdata, p_wdata;
    logic [COEF_W-1:0] a_rdata, b_rdata, p_rdata;

    logic [COEF_W-1:0] sum_ab;
    logic [COEF_W-1:0] mul_ab;
    logic              step;
    logic              in_range;

    assign sum_ab   = a_rdata + b_rdata;
    assign mul_ab   = a_rdata * b_rdata;
    assign in_range = (32'(i_exp) <= 32'(MAX_EXP));

    // Operand and product memories.
    pam_ram #(.DEPTH(NTERM), .WIDTH(COEF_W)) u_ram_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (mem_clr),
        .i_we    (a_we),
        .i_waddr (r_ld_addr),
        .i_wdata (a_wdata),
        .i_re    (a_re),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    pam_ram #(.DEPTH(NTERM), .WIDTH(COEF_W)) u_ram_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (mem_clr),
        .i_we    (b_we),
        .i_waddr (r_ld_addr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    pam_ram #(.DEPTH(NPROD), .WIDTH(COEF_W)) u_ram_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (mem_clr),
        .i_we    (p_we),
        .i_waddr (p_addr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_addr),
        .o_rdata (p_rdata)
    );

    assign o_ready = (r_state == S_IDLE);

    // Next-state and memory control.
    always_comb begin
        n_state     = r_state;
        n_ld_addr   = r_ld_addr;
        n_ld_b      = r_ld_b;
        n_coef      = r_coef;
        n_e         = r_e;
        n_i         = r_i;
        n_j         = r_j;
        n_pe        = r_pe;
        n_found     = r_found;
        n_prod      = r_prod;
        n_pend_vld  = r_pend_vld;
        n_pend_coef = r_pend_coef;
        n_pend_exp  = r_pend_exp;
        a_re        = 1'b0;
        b_re        = 1'b0;
        p_re        = 1'b0;
        a_we        = 1'b0;
        b_we        = 1'b0;
        p_we        = 1'b0;
        mem_clr     = 1'b0;
        a_raddr     = r_i;
        b_raddr     = r_j;
        p_addr      = PW'(r_i) + PW'(r_j);
        a_wdata     = a_rdata + r_coef;
        b_wdata     = b_rdata + r_coef;
        p_wdata     = p_rdata + r_prod;
        o_push_valid = 1'b0;
        o_push      = '0;
        step        = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_req_type)
                        REQ_LOAD_A, REQ_LOAD_B: begin
                            if (in_range) begin
                                n_ld_addr = AW'(i_exp);
                                n_coef    = i_coef;
                                n_ld_b    = (i_req_type == REQ_LOAD_B);
                                a_raddr   = AW'(i_exp);
                                b_raddr   = AW'(i_exp);
                                a_re      = (i_req_type == REQ_LOAD_A);
                                b_re      = (i_req_type == REQ_LOAD_B);
                                n_state   = S_LD_WR;
                            end
                        end
                        REQ_COMPUTE: begin
                            n_e     = LAST_IDX;
                            n_found = 1'b0;
                            n_state = S_SUM_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Write back the accumulated coefficient of a loaded term.
            S_LD_WR: begin
                a_we    = !r_ld_b;
                b_we    = r_ld_b;
                n_state = S_IDLE;
            end

            S_SUM_RD: begin
                a_raddr = r_e;
                b_raddr = r_e;
                a_re    = 1'b1;
                b_re    = 1'b1;
                n_state = S_SUM_CHK;
            end

            // Emit a nonzero sum term, waiting on the output if needed.
            S_SUM_CHK: begin
                if (sum_ab != '0) begin
                    o_push_valid = 1'b1;
                    o_push = '{section: SECT_SUM, coef: sum_ab,
                               exponent: OEXP_W'(r_e), last: 1'b0};
                    step   = i_push_ready;
                end
                if (step) begin
                    n_found = r_found || (sum_ab != '0);
                    if (r_e == '0) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = n_found ? S_PR_RD : S_SUM_EMPTY;
                    end else begin
                        n_e     = r_e - 1'b1;
                        n_state = S_SUM_RD;
                    end
                end
            end

            S_SUM_EMPTY: begin
                o_push_valid = 1'b1;
                o_push = '{section: SECT_SUM, coef: '0, exponent: '0, last: 1'b0};
                if (i_push_ready) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = S_PR_RD;
                end
            end

            // Product: read both coefficients and the partial sum at i+j.
            S_PR_RD: begin
                a_re    = 1'b1;
                b_re    = 1'b1;
                p_re    = 1'b1;
                n_state = S_PR_MUL;
            end

            S_PR_MUL: begin
                n_prod  = mul_ab;
                n_state = S_PR_WR;
            end

            S_PR_WR: begin
                p_we = 1'b1;
                if (r_j == LAST_IDX) begin
                    n_j = '0;
                    if (r_i == LAST_IDX) begin
                        n_pe       = LAST_PIDX;
                        n_pend_vld = 1'b0;
                        n_state    = S_PE_RD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_PR_RD;
                    end
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_PR_RD;
                end
            end

            S_PE_RD: begin
                p_addr  = r_pe;
                p_re    = 1'b1;
                n_state = S_PE_CHK;
            end

            // A nonzero product term is held back one step so that the
            // final one can carry the last mark.
            S_PE_CHK: begin
                p_addr = r_pe;
                if ((p_rdata != '0) && r_pend_vld) begin
                    o_push_valid = 1'b1;
                    o_push = '{section: SECT_PROD, coef: r_pend_coef,
                               exponent: r_pend_exp, last: 1'b0};
                    step   = i_push_ready;
                end
                if (step) begin
                    if (p_rdata != '0) begin
                        n_pend_vld  = 1'b1;
                        n_pend_coef = p_rdata;
                        n_pend_exp  = OEXP_W'(r_pe);
                    end
                    if (r_pe == '0) begin
                        n_state = S_PE_FIN;
                    end else begin
                        n_pe    = r_pe - 1'b1;
                        n_state = S_PE_RD;
                    end
                end
            end

            // Final product term (or the empty term), then clear all stores.
            S_PE_FIN: begin
                o_push_valid = 1'b1;
                o_push = '{section: SECT_PROD,
                           coef: r_pend_vld ? r_pend_coef : '0,
                           exponent: r_pend_vld ? r_pend_exp : '0,
                           last: 1'b1};
                if (i_push_ready) begin
                    mem_clr = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_found    <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_found    <= n_found;
            r_pend_vld <= n_pend_vld;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_ld_addr   <= n_ld_addr;
        r_ld_b      <= n_ld_b;
        r_coef      <= n_coef;
        r_e         <= n_e;
        r_i         <= n_i;
        r_j         <= n_j;
        r_pe        <= n_pe;
        r_prod      <= n_prod;
        r_pend_coef <= n_pend_coef;
        r_pend_exp  <= n_pend_exp;
    end

endmodule

`default_nettype wire

FILE: rtl/core/polynomial_add_multiply.sv
// Sparse polynomial addition and multiplication over dense coefficient stores.
//
// Input stream (s_axis): one request per beat. tuser carries the request kind:
// load a term of the first operand, load a term of the second, or compute.
// Loaded terms with equal exponents accumulate; exponents above MAX_EXP and
// the unused request code are dropped without any result.
// Output stream (m_axis): on a compute request the nonzero sum terms come out
// in descending exponent order (tuser 0), then the nonzero product terms
// (tuser 1); an empty section gives the single term 0 0. tlast marks the
// final product term. Both operands are then cleared for the next case.
// Sequencing: a load is a read-modify-write of an operand memory. A compute
// is set by the product loop, which takes each coefficient pair in turn
// through the states read, multiply and write of the product memory.
// Output stalls hold the sequencer; one request is worked on at a time.
// Reset (synchronous, active low) empties all stores and the output register.
// A result waits in the output register while tready is low; the sequencer
// holds until the register can take the next term.
`default_nettype none

module polynomial_add_multiply
    import pam_pkg::*;
#(
    parameter int MAX_EXP = MAX_EXP_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // term_coef[31:0], term_exponent[35:32]
    input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // out_coef[31:0], out_exponent[36:32]
    output logic [0:0]       m_axis_tuser,  // section[0]
    output logic             m_axis_tlast   // last
);

`include "polynomial_add_multiply_assert.svh"

    logic w_push_valid;
    logic w_push_ready;
    t_res w_push;
    logic r_out_valid;
    t_res r_out;

    pam_seq #(.MAX_EXP(MAX_EXP)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_coef       (s_axis_tdata[COEF_W-1:0]),
        .i_exp        (s_axis_tdata[COEF_W+TEXP_W-1:COEF_W]),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push       (w_push)
    );

    // Output register: takes a new term when empty or being drained.
    assign w_push_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push_valid && w_push_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_valid && w_push_ready) begin
            r_out <= w_push;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.exponent, r_out.coef};
    assign m_axis_tuser  = r_out.section;
    assign m_axis_tlast  = r_out.last;

    // The sequencer never pushes a result while it is free to take a request.
    `PAM_ASSERT_IMPLY(a_no_push_when_idle, i_clk, i_rst_n, s_axis_tready, !w_push_valid)

    // Sum terms never carry the end-of-output mark.
    `PAM_ASSERT_IMPLY(a_sum_not_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == SECT_SUM), !m_axis_tlast)

    // Once the final term leaves, nothing follows in the next cycle.
    `PAM_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)

endmodule

`default_nettype wire
